[design/tcii_pkg.sv]
package tcii_pkg;

   localparam int DEF_MAX_ENTRIES = 256;

   localparam int CNT_W = 9;
   localparam int IDX_W = 8;
   localparam int DAT_W = 32;
   localparam int ENT_W = 3 * DAT_W;
   localparam int OPW = DAT_W + 1;
   localparam int PW = 2 * OPW;
   localparam int ACC_W = 64;
   localparam int MASS_W = 48;
   localparam int TR_SHIFT = 17;

   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 152;

   localparam logic [REQ_USER_W-1:0] OP_WRITE = 2'd0;
   localparam logic [REQ_USER_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [REQ_USER_W-1:0] OP_MASS = 2'd2;

   typedef struct packed {
      logic ld_left;
      logic ld_cur;
      logic lk_first;
      logic lk_burn;
      logic ip_start;
      logic ip_save;
      logic ip_flow;
      logic set_tc;
      logic key_tc;
      logic ld_pf0;
      logic tr_start;
      logic tr_first;
      logic tr_tail;
      logic tr_acc;
      logic out_ld;
      logic out_mass;
   } cmd_type;

   typedef struct packed {
      logic key_le_rd;
      logic key_ge_rd;
      logic rd_ge_key;
      logic rd_gt_tc;
      logic t_nonpos;
      logic tc_gt_pt;
      logic ar_done;
      logic out_free;
   } stat_type;

endpackage

[design/thrust_curve_interpolate_integrate.sv]
// channel   dir  handshake              payload, lowest bits first
// req       in   req_tvalid/req_tready  tuser: opcode; tdata: entry_index, entry_time,
//                                       entry_thrust, entry_flow, query_time
// rsp       out  rsp_tvalid/rsp_tready  tdata: result_time, thrust, mass_flow,
//                                       mass_used, saturated, zero pad
// csr       in   csr_valid/csr_ready    csr_data: entry_count
//
// a write beat is stored without leaving idle; a lookup scans the breakpoints and,
// inside the table, runs the two interpolations on the serial multiply/divide unit
// a mass-loss beat walks the breakpoints plus one lookup and one tail term;
// each walked breakpoint costs one table read and one serial multiply
// reset (synchronous, active high) clears the count and control state; table is
// undefined until written; a finished result waits in the output register while
// the next beat is accepted
module thrust_curve_interpolate_integrate #(
   parameter int MAX_ENTRIES = tcii_pkg::DEF_MAX_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // entry_index, entry_time, entry_thrust, entry_flow, query_time
   input  logic [tcii_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode
   input  logic [tcii_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // result_time, thrust, mass_flow, mass_used, saturated, zero pad
   output logic [tcii_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tcii_pkg::CNT_W-1:0]       csr_data
);
   import tcii_pkg::*;

   cmd_type                        cmd;
   stat_type                       st;
   logic [$clog2(MAX_ENTRIES)-1:0] rd_addr;
   logic                           req_fire;

   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   tcii_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .st         (st),
      .cmd        (cmd),
      .rd_addr    (rd_addr)
   );

   tcii_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_fire   (req_fire),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .st         (st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[design/tcii_muldiv.sv]
module tcii_muldiv (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     do_div,
   input  logic [tcii_pkg::OPW-1:0] a,
   input  logic [tcii_pkg::OPW-1:0] b,
   input  logic [tcii_pkg::OPW-1:0] den,
   output logic                     done,
   output logic [tcii_pkg::PW-1:0]  prod
);
   import tcii_pkg::*;

   localparam int CNTW = $clog2(PW);

   typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV} md_state_type;

   md_state_type    state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]   p_ff, p_in;
   logic [OPW-1:0]  a_ff, a_in;
   logic [OPW-1:0]  den_ff, den_in;
   logic [OPW:0]    rem_ff, rem_in;
   logic            div_ff, div_in;
   logic            done_ff, done_in;

   logic [OPW:0]    mul_s;
   logic [OPW:0]    div_t;
   logic            div_ge;

   // shift-add multiply, then, if do_div, restoring divide of the product in place
   assign mul_s = {1'b0, p_ff[PW-1:OPW]} + (p_ff[0] ? {1'b0, a_ff} : '0);
   assign div_t = {rem_ff[OPW-1:0], p_ff[PW-1]};
   assign div_ge = div_t >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      p_in = p_ff;
      a_in = a_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      done_in = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               p_in = {{OPW{1'b0}}, b};
               a_in = a;
               den_in = den;
               div_in = do_div;
               cnt_in = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            p_in = {mul_s, p_ff[OPW-1:1]};
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(OPW - 1)) begin
               cnt_in = '0;
               rem_in = '0;
               if (div_ff) begin
                  state_in = MD_DIV;
               end else begin
                  state_in = MD_IDLE;
                  done_in = 1'b1;
               end
            end
         end
         MD_DIV: begin
            rem_in = div_ge ? div_t - {1'b0, den_ff} : div_t;
            p_in = {p_ff[PW-2:0], div_ge};
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(PW - 1)) begin
               state_in = MD_IDLE;
               done_in = 1'b1;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      p_ff <= p_in;
      a_ff <= a_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done = done_ff;
   assign prod = p_ff;

endmodule

[design/tcii_dp.sv]
module tcii_dp #(
   parameter int MAX_ENTRIES = tcii_pkg::DEF_MAX_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_fire,
   input  logic [tcii_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic [tcii_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  tcii_pkg::cmd_type                 cmd,
   input  logic [$clog2(MAX_ENTRIES)-1:0]    rd_addr,
   output tcii_pkg::stat_type                st,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [tcii_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import tcii_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = ((AW > IDX_W) ? AW : IDX_W) + 1;

   function automatic logic [OPW-1:0] mag(input logic signed [OPW-1:0] v);
      mag = v[OPW-1] ? -v : v;
   endfunction

   logic [ENT_W-1:0] mem [MAX_ENTRIES];
   logic [ENT_W-1:0] rd_q;

   logic [IDX_W-1:0]        req_idx;
   logic [CW-1:0]           idx_ext;
   logic signed [DAT_W-1:0] req_time, req_thr, req_flow, req_query;
   logic                    wr_ok;

   logic signed [DAT_W-1:0] rd_time, rd_thr, rd_flow;

   logic signed [DAT_W-1:0] t_ff, key_ff, tc_ff, pt_ff, pf_ff;
   logic signed [DAT_W-1:0] left_time_ff, left_thr_ff, left_flow_ff;
   logic signed [DAT_W-1:0] cur_time_ff, cur_thr_ff, cur_flow_ff;
   logic signed [DAT_W-1:0] lk_rt_ff, lk_th_ff, lk_fl_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    tr_neg_ff;

   logic                    rsp_valid_ff;
   logic [DAT_W-1:0]        rsp_time_ff, rsp_thr_ff, rsp_flow_ff;
   logic [MASS_W-1:0]       rsp_mass_ff;
   logic                    rsp_sat_ff;

   // interpolation operands
   logic signed [OPW-1:0]   ip_x0, ip_x1, ip_key, ip_den, ip_num, ip_num_c, ip_dy;
   logic signed [DAT_W-1:0] ip_y0, ip_y1, ip_y;
   logic [DAT_W-1:0]        ip_q;
   logic                    ip_trivial;

   // trapezoid operands
   logic signed [DAT_W-1:0] tr_f0, tr_f1, tr_t1;
   logic signed [OPW-1:0]   tr_fsum, tr_dt;
   logic [ACC_W-1:0]        tr_mag;
   logic                    tr_rnd;
   logic signed [ACC_W-1:0] tr_term;

   logic                    md_start, md_done;
   logic [OPW-1:0]          md_a, md_b, md_den;
   logic [PW-1:0]           md_prod;

   logic                    mass_sat;
   logic [MASS_W-1:0]       mass_val;

   assign req_idx = req_tdata[7:0];
   assign req_time = req_tdata[39:8];
   assign req_thr = req_tdata[71:40];
   assign req_flow = req_tdata[103:72];
   assign req_query = req_tdata[135:104];
   assign idx_ext = CW'(req_idx);
   assign wr_ok = req_fire && (req_tuser == OP_WRITE) && (idx_ext < CW'(MAX_ENTRIES));

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[idx_ext[AW-1:0]] <= {req_flow, req_thr, req_time};
      end
      rd_q <= mem[rd_addr];
   end

   assign rd_time = rd_q[31:0];
   assign rd_thr = rd_q[63:32];
   assign rd_flow = rd_q[95:64];

   assign ip_x0 = {left_time_ff[DAT_W-1], left_time_ff};
   assign ip_x1 = {cur_time_ff[DAT_W-1], cur_time_ff};
   assign ip_key = {key_ff[DAT_W-1], key_ff};
   assign ip_den = ip_x1 - ip_x0;
   assign ip_num = ip_key - ip_x0;
   // equal or reversed breakpoints and queries at the left end give the left value
   assign ip_trivial = (ip_den <= 33'sd0) || (ip_num <= 33'sd0);
   assign ip_num_c = (ip_num > ip_den) ? ip_den : ip_num;
   assign ip_y0 = cmd.ip_flow ? left_flow_ff : left_thr_ff;
   assign ip_y1 = cmd.ip_flow ? cur_flow_ff : cur_thr_ff;
   assign ip_dy = {ip_y1[DAT_W-1], ip_y1} - {ip_y0[DAT_W-1], ip_y0};
   assign ip_q = md_prod[DAT_W-1:0];
   assign ip_y = ip_dy[OPW-1] ? ip_y0 - ip_q : ip_y0 + ip_q;

   assign tr_f0 = (!cmd.tr_tail && cmd.tr_first) ? rd_flow : pf_ff;
   assign tr_f1 = cmd.tr_tail ? lk_fl_ff : rd_flow;
   assign tr_t1 = cmd.tr_tail ? tc_ff : rd_time;
   assign tr_fsum = {tr_f0[DAT_W-1], tr_f0} + {tr_f1[DAT_W-1], tr_f1};
   assign tr_dt = {tr_t1[DAT_W-1], tr_t1} - {pt_ff[DAT_W-1], pt_ff};

   // product >> 17, rounded toward minus infinity
   assign tr_mag = ACC_W'(md_prod[PW-1:TR_SHIFT]);
   assign tr_rnd = |md_prod[TR_SHIFT-1:0];
   assign tr_term = tr_neg_ff ? -(tr_mag + ACC_W'(tr_rnd)) : tr_mag;

   assign md_start = cmd.ip_start || cmd.tr_start;
   assign md_a = cmd.ip_start ? (ip_trivial ? '0 : ip_num_c) : mag(tr_fsum);
   assign md_b = cmd.ip_start ? mag(ip_dy) : mag(tr_dt);
   assign md_den = ip_trivial ? OPW'(1) : ip_den;

   tcii_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (md_start),
      .do_div (cmd.ip_start),
      .a      (md_a),
      .b      (md_b),
      .den    (md_den),
      .done   (md_done),
      .prod   (md_prod)
   );

   assign mass_sat = !((&acc_ff[ACC_W-1:MASS_W-1]) || !(|acc_ff[ACC_W-1:MASS_W-1]));
   assign mass_val = mass_sat ? (acc_ff[ACC_W-1] ? {1'b1, {(MASS_W-1){1'b0}}}
                                                 : {1'b0, {(MASS_W-1){1'b1}}})
                              : acc_ff[MASS_W-1:0];

   always_ff @(posedge clock) begin
      if (req_fire) begin
         t_ff <= req_query;
         key_ff <= req_query;
         acc_ff <= '0;
      end
      if (cmd.key_tc) begin
         key_ff <= tc_ff;
      end
      if (cmd.set_tc) begin
         tc_ff <= (t_ff >= rd_time) ? rd_time : t_ff;
         pt_ff <= '0;
      end
      if (cmd.ld_left) begin
         left_time_ff <= rd_time;
         left_thr_ff <= rd_thr;
         left_flow_ff <= rd_flow;
      end
      if (cmd.ld_cur) begin
         cur_time_ff <= rd_time;
         cur_thr_ff <= rd_thr;
         cur_flow_ff <= rd_flow;
         lk_rt_ff <= key_ff;
      end
      if (cmd.lk_first) begin
         lk_rt_ff <= rd_time;
         lk_th_ff <= rd_thr;
         lk_fl_ff <= rd_flow;
      end
      if (cmd.lk_burn) begin
         lk_rt_ff <= key_ff;
         lk_th_ff <= '0;
         lk_fl_ff <= '0;
      end
      if (cmd.ip_save) begin
         if (cmd.ip_flow) begin
            lk_fl_ff <= ip_y;
         end else begin
            lk_th_ff <= ip_y;
         end
      end
      if (cmd.ld_pf0) begin
         pf_ff <= rd_flow;
      end
      if (cmd.tr_start) begin
         tr_neg_ff <= tr_fsum[OPW-1] ^ tr_dt[OPW-1];
      end
      if (cmd.tr_acc) begin
         acc_ff <= acc_ff + tr_term;
         if (!cmd.tr_tail) begin
            pt_ff <= rd_time;
            pf_ff <= rd_flow;
         end
      end
      if (cmd.out_ld) begin
         rsp_time_ff <= cmd.out_mass ? t_ff : lk_rt_ff;
         rsp_thr_ff <= cmd.out_mass ? '0 : lk_th_ff;
         rsp_flow_ff <= cmd.out_mass ? '0 : lk_fl_ff;
         rsp_mass_ff <= cmd.out_mass ? mass_val : '0;
         rsp_sat_ff <= cmd.out_mass && mass_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_ld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign st.key_le_rd = key_ff <= rd_time;
   assign st.key_ge_rd = key_ff >= rd_time;
   assign st.rd_ge_key = rd_time >= key_ff;
   assign st.rd_gt_tc = rd_time > tc_ff;
   assign st.t_nonpos = t_ff <= 32'sd0;
   assign st.tc_gt_pt = tc_ff > pt_ff;
   assign st.ar_done = md_done;
   assign st.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'b0, rsp_sat_ff, rsp_mass_ff, rsp_flow_ff, rsp_thr_ff, rsp_time_ff};

endmodule

[design/tcii_ctrl.sv]
module tcii_ctrl #(
   parameter int MAX_ENTRIES = tcii_pkg::DEF_MAX_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic [tcii_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                             req_tready,
   input  logic                             csr_valid,
   input  logic [tcii_pkg::CNT_W-1:0]       csr_data,
   input  tcii_pkg::stat_type               st,
   output tcii_pkg::cmd_type                cmd,
   output logic [$clog2(MAX_ENTRIES)-1:0]   rd_addr
);
   import tcii_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int NW = $clog2(MAX_ENTRIES + 1);
   localparam int KW = (NW > CNT_W) ? NW : CNT_W;

   typedef enum logic [4:0] {
      S_IDLE, S_LK_START, S_L_RD0, S_L_CK0, S_L_RDL, S_L_CKL, S_L_RDI, S_L_CKI,
      S_IP_TH, S_IP_TH_W, S_IP_FL, S_IP_FL_W, S_LK_END,
      S_M_START, S_M_RDL, S_M_CKL, S_M_RDI, S_M_CKI, S_M_TR_W, S_M_TAIL,
      S_M_TAIL2, S_M_TAIL_W, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [NW-1:0]    i_ff, i_in;
   logic [AW-1:0]    addr_ff, addr_in;
   logic             mode_ff, mode_in;
   logic [CNT_W-1:0] count_ff;

   logic [KW-1:0]    cnt_ext;
   logic [NW-1:0]    n, last, i_nxt;
   logic             n_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_data;
      end
   end

   assign cnt_ext = KW'(count_ff);
   assign n = (cnt_ext > KW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : cnt_ext[NW-1:0];
   assign last = n - NW'(1);
   assign n_zero = n == '0;
   assign i_nxt = i_ff + NW'(1);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      addr_in = addr_ff;
      mode_in = mode_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_LOOKUP) begin
                  mode_in = 1'b0;
                  state_in = S_LK_START;
               end else if (req_tuser == OP_MASS) begin
                  mode_in = 1'b1;
                  state_in = S_M_START;
               end
            end
         end
         S_LK_START: begin
            if (n_zero) begin
               cmd.lk_burn = 1'b1;
               state_in = S_LK_END;
            end else begin
               addr_in = '0;
               state_in = S_L_RD0;
            end
         end
         S_L_RD0: state_in = S_L_CK0;
         S_L_CK0: begin
            if (st.key_le_rd) begin
               cmd.lk_first = 1'b1;
               state_in = S_LK_END;
            end else begin
               cmd.ld_left = 1'b1;
               addr_in = last[AW-1:0];
               state_in = S_L_RDL;
            end
         end
         S_L_RDL: state_in = S_L_CKL;
         S_L_CKL: begin
            // at or past the last breakpoint: burnout
            if (st.key_ge_rd) begin
               cmd.lk_burn = 1'b1;
               state_in = S_LK_END;
            end else begin
               i_in = NW'(1);
               addr_in = AW'(1);
               state_in = S_L_RDI;
            end
         end
         S_L_RDI: state_in = S_L_CKI;
         S_L_CKI: begin
            if (st.rd_ge_key || i_ff == last) begin
               cmd.ld_cur = 1'b1;
               state_in = S_IP_TH;
            end else begin
               cmd.ld_left = 1'b1;
               i_in = i_nxt;
               addr_in = i_nxt[AW-1:0];
               state_in = S_L_RDI;
            end
         end
         S_IP_TH: begin
            cmd.ip_start = 1'b1;
            state_in = S_IP_TH_W;
         end
         S_IP_TH_W: begin
            if (st.ar_done) begin
               cmd.ip_save = 1'b1;
               state_in = S_IP_FL;
            end
         end
         S_IP_FL: begin
            cmd.ip_start = 1'b1;
            cmd.ip_flow = 1'b1;
            state_in = S_IP_FL_W;
         end
         S_IP_FL_W: begin
            cmd.ip_flow = 1'b1;
            if (st.ar_done) begin
               cmd.ip_save = 1'b1;
               state_in = S_LK_END;
            end
         end
         S_LK_END: state_in = mode_ff ? S_M_TAIL2 : S_DONE;
         S_M_START: begin
            if (n_zero || st.t_nonpos) begin
               state_in = S_DONE;
            end else begin
               addr_in = last[AW-1:0];
               state_in = S_M_RDL;
            end
         end
         S_M_RDL: state_in = S_M_CKL;
         S_M_CKL: begin
            cmd.set_tc = 1'b1;
            i_in = '0;
            addr_in = '0;
            state_in = S_M_RDI;
         end
         S_M_RDI: state_in = S_M_CKI;
         S_M_CKI: begin
            cmd.ld_pf0 = i_ff == '0;
            if (st.rd_gt_tc) begin
               state_in = S_M_TAIL;
            end else begin
               cmd.tr_start = 1'b1;
               cmd.tr_first = i_ff == '0;
               state_in = S_M_TR_W;
            end
         end
         S_M_TR_W: begin
            if (st.ar_done) begin
               cmd.tr_acc = 1'b1;
               if (i_ff == last) begin
                  state_in = S_M_TAIL;
               end else begin
                  i_in = i_nxt;
                  addr_in = i_nxt[AW-1:0];
                  state_in = S_M_RDI;
               end
            end
         end
         S_M_TAIL: begin
            // partial interval up to the clamped time needs the flow there
            if (st.tc_gt_pt) begin
               cmd.key_tc = 1'b1;
               state_in = S_LK_START;
            end else begin
               state_in = S_DONE;
            end
         end
         S_M_TAIL2: begin
            cmd.tr_start = 1'b1;
            cmd.tr_tail = 1'b1;
            state_in = S_M_TAIL_W;
         end
         S_M_TAIL_W: begin
            cmd.tr_tail = 1'b1;
            if (st.ar_done) begin
               cmd.tr_acc = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (st.out_free) begin
               cmd.out_ld = 1'b1;
               cmd.out_mass = mode_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
      end
      i_ff <= i_in;
      addr_ff <= addr_in;
   end

   assign req_tready = state_ff == S_IDLE;
   assign rd_addr = addr_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      st.ar_done |-> (state_ff == S_IP_TH_W || state_ff == S_IP_FL_W ||
                      state_ff == S_M_TR_W || state_ff == S_M_TAIL_W))
      else $error("arith unit finished outside a wait state");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.ip_start || cmd.tr_start) |=> !st.ar_done)
      else $error("arith unit done right after start");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_L_CKI || state_ff == S_M_CKI) |-> (i_ff <= last))
      else $error("table scan index past the count");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> st.out_free)
      else $error("result loaded over an untaken beat");

endmodule
